### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define SITDA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("sitda assertion failed");

// condition must never be true at a clock edge out of reset
`define SITDA_NEVER(lbl, cond) `SITDA_ASSERT(lbl, !(cond))

`endif

### hw/rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants, types and the binary-to-BCD step for the itoa block.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int VALUE_BITS    = 64;
	localparam int INPUT_BITS    = 64;
	localparam int CHAR_BITS     = 6;
	// decimal digits of 2^(VALUE_BITS-1)
	localparam int DIGITS        = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
	localparam int BCD_BITS      = DIGITS * 4;
	localparam int BITS_PER_STEP = 4;
	localparam int STEPS         = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int PAD_BITS      = STEPS * BITS_PER_STEP;
	localparam int STEP_W        = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int IDX_W         = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int QUEUE_DEPTH   = 2;
	localparam int PTR_W         = $clog2(QUEUE_DEPTH);
	localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 6'd48;
	localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 6'd45;

	typedef logic [BCD_BITS-1:0] bcd_t;

	typedef struct packed {
		logic                  negative;
		logic [VALUE_BITS-1:0] magnitude;
	} job_t;

	typedef struct packed {
		logic empty;
		job_t job;
	} queue_head_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIND,
		ST_EMIT
	} back_state_t;

	// one double-dabble bit: add-3 on digits >= 5, then shift in the bit
	function automatic bcd_t dd_step(input bcd_t b, input logic in_bit);
		bcd_t       r;
		logic [3:0] dig;
		for (int d = 0; d < DIGITS; d++) begin
			dig = b[4*d +: 4];
			if (dig >= 4'd5) begin
				dig = dig + 4'd3;
			end
			r[4*d +: 4] = dig;
		end
		return {r[BCD_BITS-2:0], in_bit};
	endfunction

endpackage

### hw/rtl/sitda_front.sv
// ----------------------------------------------------------------------------
// sitda_front
// Input stage: takes a word, splits it into sign and unsigned magnitude.
// ----------------------------------------------------------------------------
module sitda_front import sitda_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [INPUT_BITS-1:0] value,
	output logic                  q_push,
	output job_t                  q_job,
	input  logic                  q_full
);

	logic                  v_s1;
	job_t                  job_s1;
	logic [VALUE_BITS-1:0] raw;
	logic                  accept;

	assign raw    = value[VALUE_BITS-1:0];
	assign full   = v_s1 && q_full;
	assign accept = push && !full;
	assign q_push = v_s1 && !q_full;
	assign q_job  = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1.negative  <= raw[VALUE_BITS-1];
			job_s1.magnitude <= raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
		end
	end

endmodule

### hw/rtl/sitda_queue.sv
// ----------------------------------------------------------------------------
// sitda_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sitda_queue import sitda_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  job_t        push_job,
	output logic        full,
	input  logic        pop,
	output queue_head_t head
);

	job_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign head.empty = (cnt_q == '0);
	assign head.job   = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && !head.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	`SITDA_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(QUEUE_DEPTH))
	`SITDA_NEVER(a_no_underflow, pop && cnt_q == '0)

endmodule

### hw/rtl/sitda_back.sv
// ----------------------------------------------------------------------------
// sitda_back
// Conversion engine: 4-bit-per-cycle double dabble, then character emission.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sitda_back import sitda_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  queue_head_t          head,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic [CHAR_BITS-1:0] character,
	output logic                 last
);

	back_state_t           state_q;
	back_state_t           state_d;
	logic                  neg_q;
	logic                  sign_q;
	logic [PAD_BITS-1:0]   mag_q;
	bcd_t                  bcd_q;
	bcd_t                  bcd_next;
	logic [STEP_W-1:0]     step_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      lead;
	logic                  out_valid_q;
	logic [CHAR_BITS-1:0]  char_q;
	logic                  last_q;
	logic                  slot_free;
	logic                  emit;
	logic [CHAR_BITS-1:0]  emit_char;
	logic                  emit_last;
	logic [3:0]            cur_digit;

	assign slot_free = !out_valid_q || pop;
	assign cur_digit = bcd_q[{idx_q, 2'b00} +: 4];
	assign empty     = !out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	always_comb begin
		bcd_next = bcd_q;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			bcd_next = dd_step(bcd_next, mag_q[PAD_BITS-1-b]);
		end
	end

	always_comb begin
		lead = '0;
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[4*d +: 4] != 4'd0) begin
				lead = IDX_W'(d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_char = ASCII_ZERO + {2'b00, cur_digit};
		emit_last = (idx_q == '0);
		unique case (state_q)
			ST_IDLE: begin
				if (!head.empty) begin
					q_pop   = 1'b1;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (step_q == STEP_W'(STEPS - 1)) begin
					state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					emit = 1'b1;
					if (sign_q) begin
						emit_char = ASCII_MINUS;
						emit_last = 1'b0;
					end else if (emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				neg_q  <= head.job.negative;
				mag_q  <= PAD_BITS'(head.job.magnitude);
				bcd_q  <= '0;
				step_q <= '0;
			end
			ST_CONV: begin
				bcd_q  <= bcd_next;
				mag_q  <= mag_q << BITS_PER_STEP;
				step_q <= step_q + 1'b1;
			end
			ST_FIND: begin
				idx_q  <= lead;
				sign_q <= neg_q;
			end
			ST_EMIT: begin
				if (emit) begin
					if (sign_q) begin
						sign_q <= 1'b0;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	`SITDA_NEVER(a_char_legal, !empty && character != ASCII_MINUS && character - ASCII_ZERO > 6'd9)
	`SITDA_NEVER(a_minus_not_last, !empty && character == ASCII_MINUS && last)
	`SITDA_ASSERT(a_idx_range, state_q == ST_EMIT |-> idx_q <= IDX_W'(DIGITS - 1))

endmodule

### hw/rtl/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Signed integer to decimal ASCII text, one character per output word.
// ----------------------------------------------------------------------------
// Input channel: push/full. A word is taken when push is high and full low;
// value is read as a VALUE_BITS-wide two's complement integer.
// Output channel: empty/pop. While empty is low, character and last hold the
// oldest waiting character; it is taken when pop is high and empty low.
// Each input word yields its decimal text, most significant first: a '-' for
// negative values, no leading zeros, '0' for zero; last marks the final one.
// The front stage and a two-entry queue take new words while the back part
// converts, so input and output stall independently.
// Per word: the back part picks it up from the queue, runs STEPS steps of
// double dabble at 4 bits per cycle (16 for 64-bit values), finds the
// leading digit, then emits one character per cycle while pop keeps up; a
// number has up to twenty characters. The shared conversion loop sets the rate.
// A receiver holding pop low freezes emission; nothing is lost or repeated.
// Reset clears the queue, the front stage and the output register.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top import sitda_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [INPUT_BITS-1:0] value,
	output logic                  empty,
	input  logic                  pop,
	output logic [CHAR_BITS-1:0]  character,
	output logic                  last
);

	logic        q_push;
	job_t        q_job;
	logic        q_full;
	logic        q_pop;
	queue_head_t q_head;

	sitda_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.value  (value),
		.q_push (q_push),
		.q_job  (q_job),
		.q_full (q_full)
	);

	sitda_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head)
	);

	sitda_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.character (character),
		.last      (last)
	);

endmodule

### tb/signed_int_to_decimal_ascii_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top_tb
// Self-checking bench for the signed integer to decimal ASCII converter.
// Each pushed word is expanded by an in-bench model into its expected run of
// characters ('-' then digits, last flag on the final one). Every popped word
// is matched in order against that run. Directed extremes come first, then
// random values of all lengths under random idling on both sides, a long
// output stall that backs up the input, and back-to-back traffic.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top_tb import sitda_pkg::*;;

	typedef struct {
		logic [CHAR_BITS-1:0] character;
		logic                 last;
	} text_char_t;

	localparam logic [INPUT_BITS-1:0] VALUE_MASK    =
		{INPUT_BITS{1'b1}} >> (INPUT_BITS - VALUE_BITS);
	localparam logic [INPUT_BITS-1:0] MOST_POSITIVE = VALUE_MASK >> 1;
	localparam logic [INPUT_BITS-1:0] MOST_NEGATIVE = ~MOST_POSITIVE;
	localparam int                    SETTLE_CYCLES = 60;

	logic                  clk    = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push   = 1'b0;
	logic                  full;
	logic [INPUT_BITS-1:0] value  = '0;
	logic                  empty;
	logic                  pop    = 1'b0;
	logic [CHAR_BITS-1:0]  character;
	logic                  last;

	text_char_t expected_text[$];
	int         fail_count    = 0;
	int         send_idle_pct = 50;
	int         recv_idle_pct = 50;
	int         drain_hold    = 0;

	signed_int_to_decimal_ascii_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.value     (value),
		.empty     (empty),
		.pop       (pop),
		.character (character),
		.last      (last)
	);

	always #1 clk = ~clk;

	function automatic int draw_gap(input int pct);
		return ($urandom_range(0, 99) < pct) ? int'($urandom_range(0, 15)) : 0;
	endfunction

	// decimal text of the low VALUE_BITS bits, read as two's complement
	function automatic void queue_decimal_text(input logic [INPUT_BITS-1:0] v);
		logic [INPUT_BITS-1:0] raw;
		logic [INPUT_BITS-1:0] mag;
		logic [3:0]            digits[$];
		text_char_t            c;
		raw = v & VALUE_MASK;
		mag = raw[VALUE_BITS-1] ? ((~raw + 1'b1) & VALUE_MASK) : raw;
		do begin
			digits.push_front(4'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (raw[VALUE_BITS-1]) begin
			c.character = ASCII_MINUS;
			c.last      = 1'b0;
			expected_text.push_back(c);
		end
		foreach (digits[i]) begin
			c.character = ASCII_ZERO + CHAR_BITS'(digits[i]);
			c.last      = (i == digits.size() - 1);
			expected_text.push_back(c);
		end
	endfunction

	function automatic logic [INPUT_BITS-1:0] random_value();
		logic [INPUT_BITS-1:0] r;
		r = INPUT_BITS'({$urandom, $urandom});
		case ($urandom_range(0, 3))
			0: return r;
			1: return r >> $urandom_range(0, INPUT_BITS - 1);
			2: return -(r >> $urandom_range(0, INPUT_BITS - 1));
			default: begin
				r = INPUT_BITS'($urandom_range(0, 1000));
				return $urandom_range(0, 1) ? -r : r;
			end
		endcase
	endfunction

	task automatic send_word(input logic [INPUT_BITS-1:0] v);
		int gap;
		gap = draw_gap(send_idle_pct);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push  <= 1'b1;
		value <= v;
		do @(posedge clk); while (full);
		queue_decimal_text(v);
	endtask

	// pops and checks every output word
	initial begin : char_checker
		int         gap;
		text_char_t exp_c;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap(recv_idle_pct);
			if (drain_hold > 0) begin
				gap        = drain_hold;
				drain_hold = 0;
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (expected_text.size() == 0) begin
				$error("unexpected word: character %0d last %0b", character, last);
				fail_count++;
			end else begin
				exp_c = expected_text.pop_front();
				if (character !== exp_c.character) begin
					$error("character mismatch: expected %0d, actual %0d",
						exp_c.character, character);
					fail_count++;
				end
				if (last !== exp_c.last) begin
					$error("last mismatch: expected %0b, actual %0b", exp_c.last, last);
					fail_count++;
				end
			end
		end
	end

	task automatic test_extremes();
		logic [INPUT_BITS-1:0] vals[$];
		send_idle_pct = 50;
		recv_idle_pct = 50;
		vals = '{
			'0, 64'd1, -64'd1, 64'd9, 64'd10, -64'd10, 64'd99, 64'd100,
			64'd1234567890, -64'd9876543210,
			64'd999999999999999999, 64'd1000000000000000000, -64'd999999999999999999,
			MOST_POSITIVE, MOST_NEGATIVE, MOST_NEGATIVE + 1'b1, MOST_POSITIVE - 1'b1,
			~VALUE_MASK, ~VALUE_MASK | 64'd7, {INPUT_BITS{1'b1}}
		};
		foreach (vals[i]) send_word(vals[i]);
	endtask

	task automatic test_random_values();
		int pcts[3] = '{0, 30, 100};
		for (int i = 0; i < 100; i++) begin
			if (i % 25 == 0) begin
				send_idle_pct = pcts[$urandom_range(0, 2)];
				recv_idle_pct = pcts[$urandom_range(0, 2)];
			end
			send_word(random_value());
		end
	endtask

	// receiver stalls long enough for the input side to fill and push back
	task automatic test_output_stall();
		send_idle_pct = 0;
		recv_idle_pct = 20;
		drain_hold    = 400;
		for (int i = 0; i < 15; i++) send_word(random_value());
	endtask

	task automatic test_back_to_back();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 15; i++) send_word(random_value());
	endtask

	initial begin : main
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_random_values();
		test_output_stall();
		test_back_to_back();
		push <= 1'b0;
		while (expected_text.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin : watchdog
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
